// File: design/joystick_report_decode_lpf_macros.svh
// Assertion macros for the checker of the report decoder.
`ifndef JOYSTICK_REPORT_DECODE_LPF_MACROS_SVH
`define JOYSTICK_REPORT_DECODE_LPF_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/jrd_pkg.sv
// Types and constants shared by the report decoder modules.
package jrd_pkg;

  localparam int ACC_W    = 10;
  localparam int GAIN_W   = 11;
  localparam int FRAC_W   = 10;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 80;

  localparam logic [GAIN_W-1:0] LPF_FULL = 11'd1024;
  localparam logic [GAIN_W-1:0] LPF_HALF = 11'd512;

  typedef logic [IN_W-1:0]   in_word_t;
  typedef logic [OUT_W-1:0]  out_word_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [GAIN_W-1:0] gain_t;

  // Control sent to every filter lane.
  typedef struct packed {
    logic  upd;
    gain_t gain;
  } lane_ctrl_t;

  // What one lane reports: both values already offset by half range.
  typedef struct packed {
    acc_t accel;
    acc_t filt;
  } lane_res_t;

endpackage

// File: design/jrd_lane.sv
// One accelerometer axis: rebuild the 10-bit sample and update its low-pass accumulator.
module jrd_lane
  import jrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  logic [7:0] high,
  input  logic [1:0] low,
  output lane_res_t  res
);

  localparam int DIFF_W = ACC_W + 1;
  localparam int GS_W   = GAIN_W + 1;
  localparam int PROD_W = DIFF_W + GS_W;
  localparam int STEP_W = PROD_W - FRAC_W;

  acc_t                     raw;
  acc_t                     smooth_r;
  acc_t                     smooth_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic signed [GS_W-1:0]   gain_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] sum;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W-1:0] acc_wide;

  assign raw = {high, low};

  // old*f + raw*(1024-f) == old*1024 + (raw-old)*gain, so one multiply closes the loop.
  always_comb begin
    diff     = $signed({1'b0, raw}) - $signed({1'b0, smooth_r});
    gain_s   = $signed({1'b0, ctrl.gain});
    prod     = diff * gain_s;
    sum      = prod + $signed({{(PROD_W-GAIN_W){1'b0}}, LPF_HALF});
    step     = sum[PROD_W-1:FRAC_W];
    acc_wide = $signed({{(STEP_W-ACC_W){1'b0}}, smooth_r}) + step;
    smooth_nxt = acc_wide[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= '0;
    end else if (ctrl.upd) begin
      smooth_r <= smooth_nxt;
    end
  end

  // Subtracting half range is a flip of the top bit.
  assign res.accel = {~raw[ACC_W-1], raw[ACC_W-2:0]};
  assign res.filt  = {~smooth_nxt[ACC_W-1], smooth_nxt[ACC_W-2:0]};

endmodule

// File: design/jrd_out_buf.sv
// Output register with a skid stage, so the input side never waits on a combinational ready.
module jrd_out_buf
  import jrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_data,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  out_word_t skid_data_r, skid_data_nxt;
  logic      pop;

  assign pop = out_valid_r & out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      // Output slot frees up: refill from the skid first, else from the new transaction.
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      // Output stalled: park the new result.
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign room      = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/joystick_report_decode_lpf.sv
// Top level of the six-byte controller report decoder with accelerometer low-pass filters.
//
// Takes one report per clock while in_tready is high and returns one result per report,
// registered and in order. Three filter lanes (X, Y, Z) run side by side; each
// updates its 10-bit accumulator with a single multiply-add per report, which is what
// sets the one-report-per-cycle rate. An output register plus a one-entry skid stage
// sit on the result side, so in_tready depends only on a register: it drops only while
// the skid stage holds a result, i.e. after the output side has stalled with a second
// result behind the first. Configuration: cfg_data is the old-value weight out of 1024
// (values above 1024 act as 1024, which freezes the accumulators); cfg_ready is always
// high, and it should be written only while no transaction is in flight. Accumulators
// reset to zero, the weight to zero (raw samples pass straight through).
module joystick_report_decode_lpf
  import jrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input report
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] joy_x_byte, [15:8] joy_y_byte, [23:16] accel_x_high, [31:24] accel_y_high,
  // [39:32] accel_z_high, [47:40] low_bits_buttons
  input  logic [47:0] in_tdata,
  // Decoded result
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] button_z_pressed, [1] button_c_pressed, [9:2] joy_x, [17:10] joy_y,
  // [27:18] accel_x, [37:28] accel_y, [47:38] accel_z, [57:48] filtered_x,
  // [67:58] filtered_y, [77:68] filtered_z, [79:78] zero
  output logic [79:0] out_tdata,
  // Filter weight register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  gain_t      gain_r, gain_nxt;
  lane_ctrl_t ctrl;
  lane_res_t  res_x, res_y, res_z;
  logic       accept;
  logic [7:0] joy_x_byte, joy_y_byte, ax_hi, ay_hi, az_hi, low_bits;
  out_word_t  result;

  assign cfg_ready = 1'b1;

  // Store the new-sample weight 1024 - min(factor, 1024) so each lane needs one multiply.
  always_comb begin
    if (cfg_data > LPF_FULL) begin
      gain_nxt = '0;
    end else begin
      gain_nxt = LPF_FULL - cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= LPF_FULL;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= gain_nxt;
    end
  end

  // Unpack the report.
  assign joy_x_byte = in_tdata[7:0];
  assign joy_y_byte = in_tdata[15:8];
  assign ax_hi      = in_tdata[23:16];
  assign ay_hi      = in_tdata[31:24];
  assign az_hi      = in_tdata[39:32];
  assign low_bits   = in_tdata[47:40];

  assign accept    = in_tvalid & in_tready;
  assign ctrl.upd  = accept;
  assign ctrl.gain = gain_r;

  jrd_lane u_lane_x (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ctrl),
    .high (ax_hi),
    .low  (low_bits[3:2]),
    .res  (res_x)
  );

  jrd_lane u_lane_y (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ctrl),
    .high (ay_hi),
    .low  (low_bits[5:4]),
    .res  (res_y)
  );

  jrd_lane u_lane_z (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ctrl),
    .high (az_hi),
    .low  (low_bits[7:6]),
    .res  (res_z)
  );

  // Merge buttons, joystick and the three lanes into one result word.
  // Buttons are active low; joystick minus 128 is a flip of the top bit.
  assign result = {2'b00,
                   res_z.filt, res_y.filt, res_x.filt,
                   res_z.accel, res_y.accel, res_x.accel,
                   ~joy_y_byte[7], joy_y_byte[6:0],
                   ~joy_x_byte[7], joy_x_byte[6:0],
                   ~low_bits[1], ~low_bits[0]};

  jrd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(result),
    .room     (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

endmodule

// File: design/jrd_checker.sv
// Port-level checker for the report decoder, bound to the top level.
`include "joystick_report_decode_lpf_macros.svh"

module jrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // A stalled result stays put.
  `JRD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `JRD_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")

  // Backpressure on the input only while a result is already waiting.
  `JRD_ASSERT_NOW(a_ready_low, !in_tready, out_tvalid, "input blocked with no result pending")

  // Every accepted report is followed by a valid result on the output on the next cycle.
  `JRD_ASSERT_NEXT(a_result_follows, in_tvalid && in_tready, out_tvalid, "accepted report gave no result")

endmodule

bind joystick_report_decode_lpf jrd_checker u_jrd_checker (.*);
